// ----- rtl/nlic_pkg.sv -----
// ----------------------------------------------------------------------------
// nlic_pkg
// Shared constants and register codes for the linear index converter.
// ----------------------------------------------------------------------------
package nlic_pkg;

    // Widths fixed by the interface
    localparam int LIN_W      = 48;
    localparam int SIZE_W     = 12;
    localparam int AXES_W     = 3;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;

    // Default build parameters
    localparam int DEF_MAX_AXES  = 4;
    localparam int DEF_AXIS_BITS = 12;

    // Reset value of the axis count register
    localparam logic [AXES_W-1:0] AXES_RESET = 3'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXES  = 3'd0,
        CFG_SIZE0 = 3'd1,
        CFG_SIZE1 = 3'd2,
        CFG_SIZE2 = 3'd3,
        CFG_SIZE3 = 3'd4
    } t_cfg_reg;

    // Opcodes
    localparam logic OP_TO_LINEAR = 1'b0;
    localparam logic OP_TO_COORD  = 1'b1;

endpackage

// ----- rtl/nd_linear_index_converter_unit.sv -----
// ----------------------------------------------------------------------------
// nd_linear_index_converter_unit
// Row-major conversion between up to four voxel coordinates and a linear
// index, with voxel total and invalid-geometry flag on every result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries an opcode, four coordinates
//   and a linear index. Opcode 0 forms the linear index, opcode 1 splits
//   the index into coordinates, last axis in use fastest.
//   Output channel (o_valid / i_stall) carries one result per transfer.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no item is in flight.
//   Every item passes five stages of stride multiply and index sum, one
//   48-stage divider per axis and the output register, for both opcodes.
//   Throughput is one item per cycle while the receiver does not stall.
//   A stall while a result waits in the output register freezes the whole
//   pipeline and raises o_stall; nothing is lost or repeated.
//   Reset empties the pipeline, sets the axis count to 3 and all axis
//   sizes to zero.
// ----------------------------------------------------------------------------
module nd_linear_index_converter_unit #(
    parameter int MAX_AXES  = nlic_pkg::DEF_MAX_AXES,
    parameter int AXIS_BITS = nlic_pkg::DEF_AXIS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [AXIS_BITS-1:0]          i_coord_in0,
    input  logic [AXIS_BITS-1:0]          i_coord_in1,
    input  logic [AXIS_BITS-1:0]          i_coord_in2,
    input  logic [AXIS_BITS-1:0]          i_coord_in3,
    input  logic [nlic_pkg::LIN_W-1:0]    i_linear_in,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nlic_pkg::LIN_W-1:0]    o_linear_out,
    output logic [AXIS_BITS-1:0]          o_coord_out0,
    output logic [AXIS_BITS-1:0]          o_coord_out1,
    output logic [AXIS_BITS-1:0]          o_coord_out2,
    output logic [AXIS_BITS-1:0]          o_coord_out3,
    output logic [nlic_pkg::LIN_W-1:0]    o_voxel_total,
    output logic                          o_meta_invalid,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [nlic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nlic_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int LIN_W  = nlic_pkg::LIN_W;
    localparam int SZ_W   = (AXIS_BITS < nlic_pkg::SIZE_W) ? AXIS_BITS : nlic_pkg::SIZE_W;
    localparam int ST_W   = 3 * SZ_W;
    localparam int TOT_W  = 4 * SZ_W;
    localparam int PR_W   = AXIS_BITS + ST_W;
    localparam int CRD_W  = 4 * AXIS_BITS;
    localparam int SIDE_W = 2 + 2 * LIN_W + CRD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [nlic_pkg::AXES_W-1:0] r_axes;
    logic [nlic_pkg::SIZE_W-1:0] r_size [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes <= nlic_pkg::AXES_RESET;
            for (int a = 0; a < 4; a++) r_size[a] <= '0;
        end else if (i_cfg_we) begin
            unique case (nlic_pkg::t_cfg_reg'(i_cfg_idx))
                nlic_pkg::CFG_AXES:  r_axes    <= i_cfg_data[nlic_pkg::AXES_W-1:0];
                nlic_pkg::CFG_SIZE0: r_size[0] <= i_cfg_data[nlic_pkg::SIZE_W-1:0];
                nlic_pkg::CFG_SIZE1: r_size[1] <= i_cfg_data[nlic_pkg::SIZE_W-1:0];
                nlic_pkg::CFG_SIZE2: r_size[2] <= i_cfg_data[nlic_pkg::SIZE_W-1:0];
                nlic_pkg::CFG_SIZE3: r_size[3] <= i_cfg_data[nlic_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the axis count and derive the in-use mask and effective sizes
    logic [nlic_pkg::AXES_W-1:0] n_axes;
    logic [3:0]                  use_mask;
    logic [SZ_W-1:0]             eff_size [4];
    logic                        geo_invalid;

    always_comb begin
        n_axes = r_axes;
        if (n_axes == '0) n_axes = nlic_pkg::AXES_W'(1);
        if (n_axes > nlic_pkg::AXES_W'(MAX_AXES)) n_axes = nlic_pkg::AXES_W'(MAX_AXES);
        geo_invalid = 1'b0;
        for (int a = 0; a < 4; a++) begin
            use_mask[a] = (nlic_pkg::AXES_W'(a) < n_axes);
            eff_size[a] = use_mask[a] ? r_size[a][SZ_W-1:0] : SZ_W'(1);
            if (use_mask[a] && (r_size[a][SZ_W-1:0] == '0)) geo_invalid = 1'b1;
        end
    end

    // Global advance: the pipeline moves when the output register is empty or its result is taken
    logic en;
    logic r_ov;
    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // Front stages: strides, voxel total and index sum
    // ------------------------------------------------------------------
    logic [AXIS_BITS-1:0] coord_in [4];
    assign coord_in[0] = i_coord_in0;
    assign coord_in[1] = i_coord_in1;
    assign coord_in[2] = i_coord_in2;
    assign coord_in[3] = i_coord_in3;

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic                 r1_op, r2_op, r3_op, r4_op, r5_op;
    logic                 r1_inv, r2_inv, r3_inv, r4_inv, r5_inv;
    logic [LIN_W-1:0]     r1_lin, r2_lin, r3_lin, r4_lin, r5_lin;
    logic [AXIS_BITS-1:0] r1_c [4];
    logic [AXIS_BITS-1:0] r2_c [4];
    logic [AXIS_BITS-1:0] r3_c [4];
    logic [SZ_W-1:0]      r1_es [4];
    logic [SZ_W-1:0]      r2_es1, r2_es3;
    logic [2*SZ_W-1:0]    r2_p01, r2_p23;
    logic [ST_W-1:0]      r3_st [4];
    logic [LIN_W-1:0]     r3_tot, r4_tot, r5_tot;
    logic [LIN_W-1:0]     r4_m [4];
    logic [LIN_W-1:0]     r5_idx;

    logic [2*SZ_W-1:0]    n2_p01, n2_p23;
    logic [ST_W-1:0]      n3_st0;
    logic [TOT_W-1:0]     n3_tot;
    logic [PR_W-1:0]      n4_m [4];
    logic [LIN_W-1:0]     n5_idx;

    always_comb begin
        n2_p01 = r1_es[0] * r1_es[1];
        n2_p23 = r1_es[2] * r1_es[3];
        n3_st0 = r2_es1 * r2_p23;
        n3_tot = r2_p01 * r2_p23;
        for (int a = 0; a < 4; a++) n4_m[a] = r3_c[a] * r3_st[a];
        n5_idx = r4_m[0] + r4_m[1] + r4_m[2] + r4_m[3];
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: capture, drop coordinates of unused axes
            r1_op  <= i_opcode;
            r1_inv <= geo_invalid;
            r1_lin <= i_linear_in;
            for (int a = 0; a < 4; a++) begin
                r1_c[a]  <= use_mask[a] ? coord_in[a] : '0;
                r1_es[a] <= eff_size[a];
            end
            // stage 2: pair products
            r2_op  <= r1_op;
            r2_inv <= r1_inv;
            r2_lin <= r1_lin;
            r2_c   <= r1_c;
            r2_es1 <= r1_es[1];
            r2_es3 <= r1_es[3];
            r2_p01 <= n2_p01;
            r2_p23 <= n2_p23;
            // stage 3: strides and voxel total
            r3_op    <= r2_op;
            r3_inv   <= r2_inv;
            r3_lin   <= r2_lin;
            r3_c     <= r2_c;
            r3_st[0] <= n3_st0;
            r3_st[1] <= ST_W'(r2_p23);
            r3_st[2] <= ST_W'(r2_es3);
            r3_st[3] <= ST_W'(1);
            r3_tot   <= LIN_W'(n3_tot);
            // stage 4: coordinate times stride
            r4_op  <= r3_op;
            r4_inv <= r3_inv;
            r4_lin <= r3_lin;
            r4_tot <= r3_tot;
            for (int a = 0; a < 4; a++) r4_m[a] <= LIN_W'(n4_m[a]);
            // stage 5: index sum, wraps at the index width
            r5_op  <= r4_op;
            r5_inv <= r4_inv;
            r5_lin <= r4_lin;
            r5_tot <= r4_tot;
            r5_idx <= n5_idx;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: last axis first, one divider per axis
    // ------------------------------------------------------------------
    logic              ch_v    [MAX_AXES+1];
    logic [LIN_W-1:0]  ch_num  [MAX_AXES+1];
    logic [SIDE_W-1:0] ch_side [MAX_AXES+1];

    assign ch_v[0]    = r5_v;
    assign ch_num[0]  = r5_lin;
    assign ch_side[0] = {r5_op, r5_inv, r5_tot, r5_idx, {CRD_W{1'b0}}};

    for (genvar k = 0; k < MAX_AXES; k++) begin : g_axis
        localparam int AX = MAX_AXES - 1 - k;
        logic [SZ_W-1:0]   den;
        logic [SZ_W-1:0]   rem;
        logic [SIDE_W-1:0] side_out;

        // An axis out of use divides by one and leaves its coordinate zero
        assign den = use_mask[AX] ? r_size[AX][SZ_W-1:0] : SZ_W'(1);

        nlic_div #(
            .DIV_W  (LIN_W),
            .DEN_W  (SZ_W),
            .SIDE_W (SIDE_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_v[k]),
            .i_num   (ch_num[k]),
            .i_den   (den),
            .i_side  (ch_side[k]),
            .o_valid (ch_v[k+1]),
            .o_quo   (ch_num[k+1]),
            .o_rem   (rem),
            .o_side  (side_out)
        );

        // Insert the remainder as this axis' coordinate
        always_comb begin
            ch_side[k+1] = side_out;
            ch_side[k+1][AX*AXIS_BITS +: AXIS_BITS] = AXIS_BITS'(rem);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                 t_op, t_inv;
    logic [LIN_W-1:0]     t_tot, t_idx;
    logic [CRD_W-1:0]     t_crd;
    logic [LIN_W-1:0]     r_olin, r_otot;
    logic [AXIS_BITS-1:0] r_oc [4];
    logic                 r_oinv;

    assign {t_op, t_inv, t_tot, t_idx, t_crd} = ch_side[MAX_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= ch_v[MAX_AXES];
        end
    end

    // Zero what the opcode or an invalid geometry does not produce
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oinv <= t_inv;
            r_otot <= t_inv ? '0 : t_tot;
            r_olin <= (!t_inv && (t_op == nlic_pkg::OP_TO_LINEAR)) ? t_idx : '0;
            for (int a = 0; a < 4; a++) begin
                r_oc[a] <= (!t_inv && (t_op == nlic_pkg::OP_TO_COORD))
                           ? t_crd[a*AXIS_BITS +: AXIS_BITS] : '0;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_linear_out   = r_olin;
    assign o_coord_out0   = r_oc[0];
    assign o_coord_out1   = r_oc[1];
    assign o_coord_out2   = r_oc[2];
    assign o_coord_out3   = r_oc[3];
    assign o_voxel_total  = r_otot;
    assign o_meta_invalid = r_oinv;

endmodule

// ----- rtl/nlic_div.sv -----
// ----------------------------------------------------------------------------
// nlic_div
// Pipelined restoring divider: one quotient bit per stage, with a side
// payload that travels alongside each item.
// ----------------------------------------------------------------------------
module nlic_div #(
    parameter int DIV_W  = nlic_pkg::LIN_W,
    parameter int DEN_W  = nlic_pkg::SIZE_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DIV_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v [DIV_W];
    logic [DIV_W-1:0]  r_w [DIV_W];
    logic [DEN_W-1:0]  r_r [DIV_W];
    logic [SIDE_W-1:0] r_s [DIV_W];

    for (genvar j = 0; j < DIV_W; j++) begin : g_stage
        logic              p_v;
        logic [DIV_W-1:0]  p_w;
        logic [DEN_W-1:0]  p_r;
        logic [SIDE_W-1:0] p_s;
        logic [DEN_W:0]    t;
        logic              ge;
        logic [DEN_W-1:0]  n_r;
        logic [DIV_W-1:0]  n_w;

        // Select the previous stage, or the inputs for the first one
        if (j == 0) begin : g_first
            assign p_v = i_valid;
            assign p_w = i_num;
            assign p_r = '0;
            assign p_s = i_side;
        end else begin : g_next
            assign p_v = r_v[j-1];
            assign p_w = r_w[j-1];
            assign p_r = r_r[j-1];
            assign p_s = r_s[j-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            t   = {p_r, p_w[DIV_W-1]};
            ge  = (t >= {1'b0, i_den});
            n_r = ge ? DEN_W'(t - {1'b0, i_den}) : t[DEN_W-1:0];
            n_w = {p_w[DIV_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[j] <= n_w;
                r_r[j] <= n_r;
                r_s[j] <= p_s;
            end
        end
    end

    assign o_valid = r_v[DIV_W-1];
    assign o_quo   = r_w[DIV_W-1];
    assign o_rem   = r_r[DIV_W-1];
    assign o_side  = r_s[DIV_W-1];

endmodule
